### sv/idc_pkg.sv
// Shared types and constants for the implant/decay correlator.
// Holds the transaction structs, operation and register codes, and controller types.
// No dependencies.
package idc_pkg;

    localparam int OP_W     = 2;
    localparam int TUBE_W   = 4;
    localparam int MASK_W   = 16;
    localparam int TIME_W   = 47;
    localparam int ENERGY_W = 16;
    localparam int EVNUM_W  = 32;
    localparam int WAIT_W   = 40;
    localparam int IPT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // An other event touches tubes only when fewer masked bits than this are set.
    localparam int OTHER_LIMIT = 4;

    localparam logic [OP_W-1:0] OP_IMPLANT = 2'd0;
    localparam logic [OP_W-1:0] OP_DECAY   = 2'd1;
    localparam logic [OP_W-1:0] OP_OTHER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECAY_WAIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_CUT_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GE_ENERGY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GE_ENERGY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLANTS_PER_TUBE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [TUBE_W-1:0]   tube;
        logic [MASK_W-1:0]   tube_mask;
        logic [TIME_W-1:0]   event_time;
        logic [ENERGY_W-1:0] ge_energy;
        logic [EVNUM_W-1:0]  event_number;
    } t_in_item;

    typedef struct packed {
        logic [EVNUM_W-1:0]  implant_event;
        logic [TIME_W-1:0]   implant_time;
        logic [EVNUM_W-1:0]  decay_event;
        logic [TIME_W-1:0]   decay_time;
        logic [ENERGY_W-1:0] decay_energy;
        logic                same_event;
        logic                last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/idc_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module idc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/idc_ctrl.sv
// Controller state machine of the implant/decay correlator.
// Depends on idc_pkg for the state enum and the command and status structs.
module idc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output idc_pkg::t_dp_cmd o_cmd,
    input  idc_pkg::t_dp_sts i_sts
);

    import idc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.emit ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) n_state = i_sts.last ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EVAL: o_cmd.exec = 1'b1;
            S_READ: o_cmd.rd   = 1'b1;
            S_LOAD: o_cmd.load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### sv/idc_dp.sv
// Datapath of the implant/decay correlator: configuration, per-tube state,
// implant store and output register. Depends on idc_pkg and idc_ram.
module idc_dp #(
    parameter int TUBES        = 16,
    parameter int MAX_IMPLANTS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [idc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [idc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  idc_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output idc_pkg::t_out_item                  o_out,
    input  idc_pkg::t_dp_cmd                    i_cmd,
    output idc_pkg::t_dp_sts                    o_sts
);

    import idc_pkg::*;

    localparam int TW    = (TUBES > 1) ? $clog2(TUBES) : 1;
    localparam int XW    = (TW > TUBE_W) ? TW : TUBE_W;
    localparam int CW    = $clog2(MAX_IMPLANTS + 1);
    localparam int KW    = (MAX_IMPLANTS > 1) ? $clog2(MAX_IMPLANTS) : 1;
    localparam int DEPTH = TUBES * MAX_IMPLANTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MTUBE = (TUBES < MASK_W) ? TUBES : MASK_W;

    // Configuration registers
    logic [WAIT_W-1:0]   r_max_wait;
    logic [WAIT_W-1:0]   r_cut_time;
    logic [ENERGY_W-1:0] r_min_ge;
    logic [ENERGY_W-1:0] r_max_ge;
    logic [IPT_W-1:0]    r_ipt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wait <= '0;
            r_cut_time <= '0;
            r_min_ge   <= '0;
            r_max_ge   <= '1;
            r_ipt      <= IPT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DECAY_WAIT:    r_max_wait <= i_cfg_data[WAIT_W-1:0];
                CFG_DECAY_CUT_TIME:    r_cut_time <= i_cfg_data[WAIT_W-1:0];
                CFG_MIN_GE_ENERGY:     r_min_ge   <= i_cfg_data[ENERGY_W-1:0];
                CFG_MAX_GE_ENERGY:     r_max_ge   <= i_cfg_data[ENERGY_W-1:0];
                CFG_IMPLANTS_PER_TUBE: r_ipt      <= i_cfg_data[IPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured item and emission bookkeeping
    t_in_item        r_item;
    logic [CW-1:0]   r_cnt;
    logic [KW-1:0]   r_k;

    // Per-tube state
    logic [TIME_W-1:0] r_stamp [TUBES];
    logic              r_open  [TUBES];
    logic [CW-1:0]     r_count [TUBES];

    logic [XW-1:0]     tube_x;
    logic [TW-1:0]     tidx;
    logic              tube_ok;
    logic [CW-1:0]     lim;
    logic [CW-1:0]     cnt;
    logic [CW-1:0]     wslot;
    logic [CW-1:0]     new_cnt;
    logic              avail;
    logic [TIME_W:0]   block_end;
    logic signed [TIME_W+1:0] dt;
    logic              assoc;
    logic              egood;
    logic [4:0]        mask_bits;
    logic              other_go;
    logic [AW-1:0]     base;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic              is_implant;
    logic              is_decay;
    logic              is_other;
    logic              ram_we;
    logic [EVNUM_W+TIME_W-1:0] ram_rdata;

    assign tube_x  = XW'(r_item.tube);
    assign tidx    = tube_x[TW-1:0];
    assign tube_ok = int'(r_item.tube) < TUBES;

    assign is_implant = (r_item.operation == OP_IMPLANT) && tube_ok;
    assign is_decay   = (r_item.operation == OP_DECAY) && tube_ok;
    assign is_other   = (r_item.operation == OP_OTHER);

    always_comb begin
        if (r_ipt == '0) begin
            lim = CW'(1);
        end else if (int'(r_ipt) > MAX_IMPLANTS) begin
            lim = CW'(MAX_IMPLANTS);
        end else begin
            lim = CW'(r_ipt);
        end
    end

    assign cnt     = r_count[tidx];
    assign wslot   = (cnt >= lim) ? '0 : cnt;
    assign new_cnt = wslot + CW'(1);

    // A closed tube becomes free once its blocking time has passed.
    assign block_end = {1'b0, r_stamp[tidx]} + (TIME_W + 1)'(r_max_wait);
    assign avail = r_open[tidx] ? (r_item.event_time != '0)
                                : (block_end < {1'b0, r_item.event_time});

    // An open tube acts as if stamped at minus the blocking time.
    always_comb begin
        if (r_open[tidx]) begin
            dt = $signed({1'b0, {1'b0, r_item.event_time} + (TIME_W + 1)'(r_max_wait)});
        end else begin
            dt = $signed({2'b00, r_item.event_time}) - $signed({2'b00, r_stamp[tidx]});
        end
    end
    assign assoc = (cnt != '0) && (dt < $signed((TIME_W + 2)'(r_cut_time)));
    assign egood = (r_item.ge_energy > r_min_ge) && (r_item.ge_energy < r_max_ge);

    always_comb begin
        mask_bits = '0;
        for (int k = 0; k < MASK_W; k++) begin
            mask_bits = mask_bits + 5'(r_item.tube_mask[k]);
        end
    end
    assign other_go = is_other && (int'(mask_bits) < OTHER_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TUBES; t++) begin
                r_open[t]  <= 1'b1;
                r_count[t] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (other_go) begin
                for (int t = 0; t < MTUBE; t++) begin
                    if (r_item.tube_mask[t]) begin
                        r_open[t]  <= 1'b0;
                        r_count[t] <= '0;
                    end
                end
            end else if (is_implant) begin
                if (!avail) begin
                    r_open[tidx]  <= 1'b0;
                    r_count[tidx] <= '0;
                end else begin
                    r_count[tidx] <= new_cnt;
                    r_open[tidx]  <= (new_cnt < lim);
                end
            end else if (is_decay && assoc) begin
                r_open[tidx]  <= 1'b1;
                r_count[tidx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (other_go) begin
                for (int t = 0; t < MTUBE; t++) begin
                    if (r_item.tube_mask[t]) r_stamp[t] <= r_item.event_time;
                end
            end else if (is_implant && (!avail || new_cnt >= lim)) begin
                r_stamp[tidx] <= r_item.event_time;
            end
        end
    end

    // Implant store, one row of MAX_IMPLANTS entries per tube
    assign base   = AW'(int'(tidx) * MAX_IMPLANTS);
    assign waddr  = base + AW'(wslot);
    assign raddr  = base + AW'(r_k);
    assign ram_we = i_cmd.exec && is_implant && avail;

    idc_ram #(
        .WIDTH (EVNUM_W + TIME_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata ({r_item.event_number, r_item.event_time}),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.exec) begin
            r_cnt <= cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.capture) begin
            r_k <= '0;
        end else if (i_cmd.load) begin
            r_k <= r_k + KW'(1);
        end
    end

    // Output register
    logic      r_out_valid;
    t_out_item r_out;
    logic      last_pair;

    assign last_pair = (CW'(r_k) + CW'(1)) == r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.implant_event <= ram_rdata[EVNUM_W+TIME_W-1:TIME_W];
            r_out.implant_time  <= ram_rdata[TIME_W-1:0];
            r_out.decay_event   <= r_item.event_number;
            r_out.decay_time    <= r_item.event_time;
            r_out.decay_energy  <= r_item.ge_energy;
            r_out.same_event    <= ram_rdata[EVNUM_W+TIME_W-1:TIME_W] == r_item.event_number;
            r_out.last          <= last_pair;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_sts.emit     = is_decay && assoc && egood;
    assign o_sts.last     = last_pair;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

### sv/implant_decay_correlator.sv
// Top level of the per-tube implantation/decay correlator.
// Depends on idc_pkg, idc_ctrl, idc_dp and idc_ram.
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_ready   i_in  (t_in_item)
//   output    o_out_valid / i_out_ready o_out (t_out_item)
//   config    i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An implantation or other event passes through capture, then evaluation.
// A decay that is associated and inside the energy window then goes, per emitted
// pair, through the registered read of the implant store and the output register load.
// A stalled output holds the sequencer in its load step; the last result may
// wait in the output register while the next transaction is taken in.
// Reset is synchronous and active low; tubes come out open and empty.
module implant_decay_correlator #(
    parameter int TUBES        = 16,
    parameter int MAX_IMPLANTS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  idc_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output idc_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [idc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [idc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import idc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    idc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    idc_dp #(
        .TUBES        (TUBES),
        .MAX_IMPLANTS (MAX_IMPLANTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
